// ===== rtl/core/pbv_pkg.sv =====
// pbv_pkg: shared types and constants of the plot blob validator.
// Holds the parse phase encoding, byte offsets, and config/result structs.
// No dependencies.
package pbv_pkg;

	localparam int unsigned IDX_W  = 5;   // byte index inside a fixed-size field group
	localparam int unsigned SKIP_W = 36;  // event skip length: 32-bit count times 16

	// register indexes on the config port
	localparam logic [1:0] REG_MAGIC    = 2'd0;
	localparam logic [1:0] REG_VERSION  = 2'd1;
	localparam logic [1:0] REG_COMPACT  = 2'd2;
	localparam logic [1:0] REG_ENVELOPE = 2'd3;

	// byte offsets that trigger checks or field completion
	localparam logic [IDX_W-1:0] HDR_MAGIC_LAST   = 5'd3;
	localparam logic [IDX_W-1:0] HDR_VERSION_LAST = 5'd5;
	localparam logic [IDX_W-1:0] HDR_LAST         = 5'd19;  // 20-byte header
	localparam logic [IDX_W-1:0] NAMELEN_LAST     = 5'd1;
	localparam logic [IDX_W-1:0] TAIL_MODE        = 5'd0;
	localparam logic [IDX_W-1:0] TAIL_LAST        = 5'd3;
	localparam logic [IDX_W-1:0] MHDR_UNIT_LAST   = 5'd7;
	localparam logic [IDX_W-1:0] MHDR_SCALE_LAST  = 5'd11;
	localparam logic [IDX_W-1:0] MHDR_LAST        = 5'd15;  // 16-byte mode header
	localparam logic [IDX_W-1:0] RUNHDR_LAST      = 5'd5;

	typedef enum logic [8:0] {
		PH_HEADER  = 9'b000000001,
		PH_EVENTS  = 9'b000000010,
		PH_NAMELEN = 9'b000000100,
		PH_NAME    = 9'b000001000,
		PH_TAIL    = 9'b000010000,
		PH_MHDR    = 9'b000100000,
		PH_POINTS  = 9'b001000000,
		PH_RUNHDR  = 9'b010000000,
		PH_BUCKETS = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic [31:0] magic_word;
		logic [15:0] format_version;
		logic [7:0]  compact_mode_code;
		logic [7:0]  envelope_mode_code;
	} cfg_t;

	typedef struct packed {
		logic        blob_valid;
		logic [31:0] event_total;
		logic [31:0] point_total;
	} res_t;

endpackage

// ===== rtl/core/pbv_cfg_regs.sv =====
// pbv_cfg_regs: configuration register file of the plot blob validator.
// Depends on pbv_pkg (cfg_t, register indexes).
module pbv_cfg_regs import pbv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_word         <= 32'd0;
			cfg_q.format_version     <= 16'd0;
			cfg_q.compact_mode_code  <= 8'd0;
			cfg_q.envelope_mode_code <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAGIC:    cfg_q.magic_word         <= cfg_data;
				REG_VERSION:  cfg_q.format_version     <= cfg_data[15:0];
				REG_COMPACT:  cfg_q.compact_mode_code  <= cfg_data[7:0];
				REG_ENVELOPE: cfg_q.envelope_mode_code <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/pbv_parser.sv =====
// pbv_parser: per-byte parse state machine and running totals.
// One registered step per byte; result is combinational from the step.
// Depends on pbv_pkg.
module pbv_parser import pbv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_in,
	input  logic       last_in,
	input  cfg_t       cfg,
	output res_t       res
);

	phase_t              phase_q, phase_n;
	logic [IDX_W-1:0]    idx_q, idx_n;
	logic [31:0]         asm_q, asm_n;
	logic [SKIP_W-1:0]   skip_q, skip_n;
	logic [31:0]         runs_q, runs_n;
	logic [31:0]         pend_q, pend_n;
	logic [31:0]         events_q, events_n;
	logic [31:0]         points_q, points_n;
	logic                failed_q, failed_n;
	logic                env_q, env_n;
	logic [15:0]         bcount;

	always_comb begin
		phase_n  = phase_q;
		idx_n    = idx_q;
		asm_n    = asm_q;
		skip_n   = skip_q;
		runs_n   = runs_q;
		pend_n   = pend_q;
		events_n = events_q;
		points_n = points_q;
		failed_n = failed_q;
		env_n    = env_q;
		bcount   = asm_n[31:16];
		if (!failed_q) begin
			asm_n  = {byte_in, asm_q[31:8]};
			bcount = asm_n[31:16];
			case (phase_q)
				PH_HEADER: begin
					if (idx_q == HDR_MAGIC_LAST && asm_n != cfg.magic_word) begin
						failed_n = 1'b1;
					end else if (idx_q == HDR_VERSION_LAST &&
							asm_n[31:16] != cfg.format_version) begin
						failed_n = 1'b1;
					end else if (idx_q == HDR_LAST) begin
						events_n = asm_n;
						skip_n   = {asm_n, 4'b0000};  // 16 bytes per event
						phase_n  = (asm_n != 32'd0) ? PH_EVENTS : PH_NAMELEN;
						idx_n    = '0;
					end else begin
						idx_n = idx_q + IDX_W'(1);
					end
				end
				PH_EVENTS, PH_NAME: begin
					skip_n = skip_q - SKIP_W'(1);
					if (skip_q == SKIP_W'(1)) begin
						phase_n = (phase_q == PH_EVENTS) ? PH_NAMELEN : PH_TAIL;
						idx_n   = '0;
					end
				end
				PH_NAMELEN: begin
					if (idx_q == NAMELEN_LAST) begin
						skip_n  = SKIP_W'(asm_n[31:16]);
						phase_n = (asm_n[31:16] != 16'd0) ? PH_NAME : PH_TAIL;
						idx_n   = '0;
					end else begin
						idx_n = NAMELEN_LAST;
					end
				end
				PH_TAIL: begin
					if (idx_q == TAIL_MODE && byte_in != cfg.compact_mode_code &&
							byte_in != cfg.envelope_mode_code) begin
						failed_n = 1'b1;
					end else begin
						// compact wins when both codes are equal
						if (idx_q == TAIL_MODE) env_n = (byte_in != cfg.compact_mode_code);
						if (idx_q == TAIL_LAST) begin
							phase_n = PH_MHDR;
							idx_n   = '0;
						end else begin
							idx_n = idx_q + IDX_W'(1);
						end
					end
				end
				PH_MHDR: begin
					if ((idx_q == MHDR_UNIT_LAST || idx_q == MHDR_SCALE_LAST) &&
							asm_n == 32'd0) begin
						failed_n = 1'b1;
					end else if (idx_q == MHDR_LAST) begin
						idx_n = '0;
						if (env_q) begin
							runs_n  = asm_n;
							phase_n = (asm_n != 32'd0) ? PH_RUNHDR : PH_NAMELEN;
						end else begin
							pend_n  = asm_n;
							skip_n  = SKIP_W'({asm_n, 2'b00});  // 4 bytes per point
							phase_n = (asm_n != 32'd0) ? PH_POINTS : PH_NAMELEN;
						end
					end else begin
						idx_n = idx_q + IDX_W'(1);
					end
				end
				PH_POINTS: begin
					skip_n = skip_q - SKIP_W'(1);
					if (skip_q == SKIP_W'(1)) begin
						points_n = points_q + pend_q;
						phase_n  = PH_NAMELEN;
						idx_n    = '0;
					end
				end
				PH_RUNHDR: begin
					if (idx_q == RUNHDR_LAST) begin
						pend_n = {15'd0, bcount, 1'b0};
						skip_n = SKIP_W'({bcount, 2'b00});
						idx_n  = '0;
						if (bcount == 16'd0) begin
							// empty run closes at once
							points_n = points_q + {15'd0, bcount, 1'b0};
							runs_n   = runs_q - 32'd1;
							phase_n  = (runs_q != 32'd1) ? PH_RUNHDR : PH_NAMELEN;
						end else begin
							phase_n = PH_BUCKETS;
						end
					end else begin
						idx_n = idx_q + IDX_W'(1);
					end
				end
				PH_BUCKETS: begin
					skip_n = skip_q - SKIP_W'(1);
					if (skip_q == SKIP_W'(1)) begin
						points_n = points_q + pend_q;
						runs_n   = runs_q - 32'd1;
						phase_n  = (runs_q != 32'd1) ? PH_RUNHDR : PH_NAMELEN;
						idx_n    = '0;
					end
				end
				default: failed_n = 1'b1;
			endcase
		end
	end

	// result reflects the state after this byte
	assign res.blob_valid  = !failed_n && phase_n == PH_NAMELEN && idx_n == '0;
	assign res.event_total = events_n;
	assign res.point_total = points_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			idx_q    <= '0;
			asm_q    <= '0;
			skip_q   <= '0;
			runs_q   <= '0;
			pend_q   <= '0;
			events_q <= '0;
			points_q <= '0;
			failed_q <= 1'b0;
			env_q    <= 1'b0;
		end else if (step) begin
			if (last_in) begin
				phase_q  <= PH_HEADER;
				idx_q    <= '0;
				asm_q    <= '0;
				skip_q   <= '0;
				runs_q   <= '0;
				pend_q   <= '0;
				events_q <= '0;
				points_q <= '0;
				failed_q <= 1'b0;
				env_q    <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				idx_q    <= idx_n;
				asm_q    <= asm_n;
				skip_q   <= skip_n;
				runs_q   <= runs_n;
				pend_q   <= pend_n;
				events_q <= events_n;
				points_q <= points_n;
				failed_q <= failed_n;
				env_q    <= env_n;
			end
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_in |=> phase_q == PH_HEADER && idx_q == '0 && !failed_q)
		else $error("parser did not restart after last byte");

	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q && !(step && last_in) |=> failed_q)
		else $error("error flag dropped inside a blob");

	a_frozen_totals: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q && !(step && last_in) |=> $stable(points_q) && $stable(events_q))
		else $error("totals moved after an error");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EVENTS || phase_q == PH_NAME || phase_q == PH_POINTS ||
		 phase_q == PH_BUCKETS) |-> skip_q != '0)
		else $error("skip phase entered with nothing to skip");

	a_runs_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RUNHDR || phase_q == PH_BUCKETS) |-> runs_q != 32'd0)
		else $error("run phase with no runs left");

endmodule

// ===== rtl/core/plot_blob_validator.sv =====
// plot_blob_validator: top level, streaming validator for plot blobs.
// Instantiates pbv_cfg_regs and pbv_parser; depends on pbv_pkg.
//
// The block takes one blob byte per word on the word channel, with is_last on the final
// byte, and sustains one byte per clock cycle. Each byte is captured in an input register
// and advanced through the parser in a single registered step: the header is matched
// against magic_word and format_version, event entries, names and point or bucket data are
// skipped by a down-counter, and the mode header's unit and scale are checked for zero.
// Only the last byte of a blob makes a result word; it is loaded into the result register
// when the parser steps on that byte and carries blob_valid, event_total and point_total,
// and the parser restarts on the very next byte. A result waiting on result_stall holds
// up the input only when the byte behind it is also a last byte; other bytes keep
// flowing. Configuration words are accepted on every cycle (cfg_ready is tied high) and
// must be written only while no blob is in flight.
module plot_blob_validator import pbv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// byte channel
	input  logic        word_valid,
	output logic        word_stall,
	input  logic [7:0]  data_byte,
	input  logic        is_last,
	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic        blob_valid,
	output logic [31:0] event_total,
	output logic [31:0] point_total,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t       cfg;
	res_t       res;
	res_t       res_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       result_valid_q;
	logic       go;
	logic       step;

	pbv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1 byte may advance unless it would overwrite a result still held.
	assign go         = !(last_s1 && result_valid_q && result_stall);
	assign step       = valid_s1 && go;
	assign word_stall = valid_s1 && !go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!word_stall) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (word_valid && !word_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= is_last;
		end
	end

	pbv_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			res_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign blob_valid   = res_q.blob_valid;
	assign event_total  = res_q.event_total;
	assign point_total  = res_q.point_total;

endmodule
